@@ rtl/core/kccp_pkg.sv @@
// Shared codes, zone name table and character helpers for the command parser.
package kccp_pkg;

  // Parser phase codes; the command phases double as target codes
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PhIdle = 3'd0;
  localparam logic [PhaseW-1:0] PhDev  = 3'd1;
  localparam logic [PhaseW-1:0] PhApp  = 3'd2;
  localparam logic [PhaseW-1:0] PhKey  = 3'd3;
  localparam logic [PhaseW-1:0] PhZone = 3'd4;

  // Reply codes
  typedef enum logic [1:0] {
    ReplyNone = 2'd0,
    ReplyOk   = 2'd1,
    ReplyKo   = 2'd2
  } reply_e;

  // Field widths
  localparam int unsigned CharW    = 8;
  localparam int unsigned ZoneW    = 4;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned NibW     = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgZoneByText = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgFixedZone  = 1'd1;

  // Key store: device id at 0..7, app id at 8..15, app key at 16..31
  localparam int unsigned KeyDepth = 32;
  localparam int unsigned KeyAddrW = $clog2(KeyDepth);

  // Digit counts per command
  localparam logic [DigitW-1:0] LenId  = 6'd16;
  localparam logic [DigitW-1:0] LenKey = 6'd32;
  localparam logic [DigitW-1:0] LenShortName = 6'd5;
  localparam logic [DigitW-1:0] LenLongName  = 6'd7;

  // Zone names: six short names first, then the four long names
  localparam int unsigned NumZones = 10;
  localparam int unsigned NumShort = 6;
  localparam int unsigned ZoneSelW = $clog2(NumZones);
  localparam logic [ZoneW-1:0] ZoneLater = 4'd9;

  // Special characters
  localparam logic [CharW-1:0] ChEquals = 8'h3D;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChD      = 8'h44;
  localparam logic [CharW-1:0] ChA      = 8'h41;
  localparam logic [CharW-1:0] ChK      = 8'h4B;
  localparam logic [CharW-1:0] ChZ      = 8'h5A;
  localparam logic [CharW-1:0] ChS      = 8'h53;

  // Control word carried from the parse stage to the store stage
  typedef struct packed {
    reply_e              reply;
    logic [PhaseW-1:0]   target;
    logic                byte_wr;
    logic [IdxW-1:0]     byte_idx;
    logic [NibW-1:0]     nibble;
    logic                high_nib;
    logic [KeyAddrW-1:0] addr;
    logic [ZoneW-1:0]    zone;
    logic [MaskW-1:0]    mask;
    logic                all_done;
    logic                hide_key;
  } parse_res_t;

  // Zone name text, first character in the top byte, padded to eight characters
  function automatic logic [8*CharW-1:0] zone_name(input logic [ZoneSelW-1:0] sel);
    logic [8*CharW-1:0] name;
    case (sel)
      4'd0:    name = "EU868___";
      4'd1:    name = "US915___";
      4'd2:    name = "KR920___";
      4'd3:    name = "IN865___";
      4'd4:    name = "AU915___";
      4'd5:    name = "LATER___";
      4'd6:    name = "AS923_1_";
      4'd7:    name = "AS923_2_";
      4'd8:    name = "AS923_3_";
      4'd9:    name = "AS923_4_";
      default: name = '0;
    endcase
    return name;
  endfunction

  // Character at a position of a zone name
  function automatic logic [CharW-1:0] zone_char(input logic [ZoneSelW-1:0] sel,
                                                 input logic [2:0] pos);
    logic [8*CharW-1:0] name;
    name = zone_name(sel);
    return name[(3'd7 - pos)*CharW +: CharW];
  endfunction

  // Region code of a zone name
  function automatic logic [ZoneW-1:0] zone_code(input logic [ZoneSelW-1:0] sel);
    logic [ZoneW-1:0] code;
    case (sel)
      4'd0:    code = 4'd0;
      4'd1:    code = 4'd1;
      4'd2:    code = 4'd2;
      4'd3:    code = 4'd3;
      4'd4:    code = 4'd4;
      4'd5:    code = ZoneLater;
      4'd6:    code = 4'd5;
      4'd7:    code = 4'd6;
      4'd8:    code = 4'd7;
      4'd9:    code = 4'd8;
      default: code = ZoneLater;
    endcase
    return code;
  endfunction

  // Hex digit decode: {valid, value}, case-insensitive
  function automatic logic [NibW:0] hex_val(input logic [CharW-1:0] c);
    logic [NibW:0] res;
    res = '0;
    if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, NibW'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, NibW'(c - 8'h57)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, NibW'(c - 8'h30)};
    end
    return res;
  endfunction

endpackage

@@ rtl/core/key_config_command_parser.sv @@
// Serial command parser for identifiers, key and region, with a byte-wide key store.
// A result is held in the store stage register and then in the output register after its character is accepted.
// Throughput: one character per cycle while the output is not stalled; the key store read-modify-write
// is split over the parse and store stages with forwarding of the last write.
// Reset: parser idle, done mask, region and configuration cleared; the key store holds
// no reset and is always written before a byte is read back.
module key_config_command_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [kccp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kccp_pkg::CfgDataW-1:0]  cfg_data_i,
  // Character input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kccp_pkg::CharW-1:0]     char_in_i,
  // Result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     reply_o,
  output logic [2:0]                     target_o,
  output logic                           byte_written_o,
  output logic [3:0]                     byte_index_o,
  output logic [7:0]                     byte_value_o,
  output logic [3:0]                     zone_code_o,
  output logic [3:0]                     done_mask_o,
  output logic                           all_done_o,
  output logic                           hide_key_o
);
  import kccp_pkg::*;

  // Configuration
  logic             zone_by_text_q;
  logic [ZoneW-1:0] fixed_zone_q;

  // Parser state
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic                got_eq_q, got_eq_d;
  logic [DigitW-1:0]   digit_q, digit_d;
  logic [NumZones-1:0] match_q, match_d;
  logic                as_q, as_d;
  logic [MaskW-1:0]    mask_q, mask_d;
  logic [ZoneW-1:0]    region_q, region_d;

  // Handshake
  logic in_accept;
  logic adv_store;

  // Stage registers
  parse_res_t          res_d;
  parse_res_t          stg_q;
  logic                stg_valid_q;
  logic                out_valid_q;

  // Key store
  logic [CharW-1:0]    key_mem [KeyDepth];
  logic [KeyAddrW-1:0] rd_addr;
  logic [CharW-1:0]    rd_data_q;
  logic                fwd_valid_q;
  logic [KeyAddrW-1:0] fwd_addr_q;
  logic [CharW-1:0]    fwd_data_q;
  logic [CharW-1:0]    old_byte;
  logic [CharW-1:0]    new_byte;

  // Output payload
  parse_res_t          out_q;
  logic [CharW-1:0]    out_byte_q;

  // Parse locals
  logic [PhaseW-1:0]   ph;
  logic [MaskW-1:0]    mask_pre;
  logic [ZoneW-1:0]    region_pre;
  logic [NibW:0]       hex;
  logic [DigitW-1:0]   len;
  logic [DigitW-1:0]   digit_nx;
  logic [NumZones-1:0] match_nx;
  logic                hit_short;
  logic                hit_long;

  // Handshake: the store stage drains into the output register when it is free
  assign adv_store  = stg_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stg_valid_q && !adv_store;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Parse one character
  always_comb begin
    mask_pre   = mask_q | (zone_by_text_q ? 4'b0000 : 4'b1000);
    region_pre = zone_by_text_q ? region_q :
                 ((fixed_zone_q > ZoneLater) ? ZoneLater : fixed_zone_q);
    ph         = (phase_q > PhZone) ? PhIdle : phase_q;
    hex        = hex_val(char_in_i);
    len        = (ph == PhKey) ? LenKey : LenId;
    digit_nx   = digit_q + 6'd1;
    hit_short  = 1'b0;
    hit_long   = 1'b0;
    match_nx   = '0;

    phase_d  = ph;
    got_eq_d = got_eq_q;
    digit_d  = digit_q;
    match_d  = match_q;
    as_d     = as_q;
    mask_d   = mask_pre;
    region_d = region_pre;

    res_d          = '0;
    res_d.reply    = ReplyNone;
    res_d.target   = PhIdle;

    if (ph == PhIdle) begin
      // Pick the command letter, skip line ends
      if (char_in_i == ChD) begin
        phase_d = PhDev;
      end else if (char_in_i == ChA) begin
        phase_d = PhApp;
      end else if (char_in_i == ChK) begin
        phase_d = PhKey;
      end else if (char_in_i == ChZ) begin
        phase_d = PhZone;
      end else if (char_in_i != ChLf && char_in_i != ChCr) begin
        res_d.reply = ReplyKo;
      end
      got_eq_d = 1'b0;
    end else if (!got_eq_q) begin
      // Expect the equals sign
      res_d.target = ph;
      if (char_in_i == ChEquals) begin
        got_eq_d = 1'b1;
        digit_d  = '0;
      end else begin
        res_d.reply = ReplyKo;
        phase_d     = PhIdle;
      end
    end else if (ph != PhZone) begin
      // Hex digit into the key store
      res_d.target = ph;
      if (!hex[NibW] || digit_q >= len) begin
        res_d.reply = ReplyKo;
        phase_d     = PhIdle;
      end else begin
        res_d.byte_wr  = 1'b1;
        res_d.byte_idx = digit_q[IdxW:1];
        res_d.nibble   = hex[NibW-1:0];
        res_d.high_nib = !digit_q[0];
        case (ph)
          PhDev:   res_d.addr = {2'b00, digit_q[3:1]};
          PhApp:   res_d.addr = {2'b01, digit_q[3:1]};
          default: res_d.addr = {1'b1, digit_q[IdxW:1]};
        endcase
        digit_d = digit_nx;
        if (digit_nx == len) begin
          res_d.reply = ReplyOk;
          mask_d      = mask_pre | MaskW'(4'b0001 << (ph - PhDev));
          phase_d     = PhIdle;
        end
      end
    end else begin
      // Region name, matched one character at a time
      res_d.target = PhZone;
      if (!zone_by_text_q || digit_q >= LenLongName) begin
        res_d.reply = ReplyKo;
        phase_d     = PhIdle;
      end else begin
        for (int i = 0; i < NumZones; i++) begin
          match_nx[i] = (zone_char(ZoneSelW'(i), digit_q[2:0]) == char_in_i) &&
                        ((digit_q == '0) || match_q[i]);
        end
        match_d = match_nx;
        if (digit_q == 6'd1) begin
          as_d = match_q[NumShort] && (char_in_i == ChS);
        end
        digit_d = digit_nx;
        if (digit_nx == LenShortName && !as_q) begin
          for (int i = 0; i < NumShort; i++) begin
            if (match_nx[i]) begin
              hit_short = 1'b1;
              region_d  = zone_code(ZoneSelW'(i));
            end
          end
          res_d.reply = hit_short ? ReplyOk : ReplyKo;
          if (hit_short) begin
            mask_d = mask_pre | 4'b1000;
          end
          phase_d = PhIdle;
        end else if (digit_nx == LenLongName) begin
          for (int i = NumShort; i < NumZones; i++) begin
            if (match_nx[i]) begin
              hit_long = 1'b1;
              region_d = zone_code(ZoneSelW'(i));
            end
          end
          res_d.reply = hit_long ? ReplyOk : ReplyKo;
          if (hit_long) begin
            mask_d = mask_pre | 4'b1000;
          end
          phase_d = PhIdle;
        end
      end
    end

    res_d.zone     = region_d;
    res_d.mask     = mask_d;
    res_d.all_done = (mask_d == 4'b1111);
    res_d.hide_key = (mask_d == 4'b1111) && (region_d == ZoneLater);
  end

  // Configuration writes and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_by_text_q <= 1'b0;
      fixed_zone_q   <= '0;
      phase_q        <= PhIdle;
      got_eq_q       <= 1'b0;
      digit_q        <= '0;
      match_q        <= '0;
      as_q           <= 1'b0;
      mask_q         <= '0;
      region_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgZoneByText: zone_by_text_q <= cfg_data_i[0];
          CfgFixedZone:  fixed_zone_q   <= cfg_data_i[ZoneW-1:0];
          default:       ;
        endcase
      end
      if (in_accept) begin
        phase_q  <= phase_d;
        got_eq_q <= got_eq_d;
        digit_q  <= digit_d;
        match_q  <= match_d;
        as_q     <= as_d;
        mask_q   <= mask_d;
        region_q <= region_d;
      end
    end
  end

  // Stage and output valid flags, write forwarding flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        stg_valid_q <= 1'b1;
      end else if (adv_store) begin
        stg_valid_q <= 1'b0;
      end
      if (adv_store) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      fwd_valid_q <= adv_store && stg_q.byte_wr;
    end
  end

  // Hold the parse result in the store stage
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stg_q <= res_d;
    end
  end

  // Key store: read at the incoming address, or keep reading the held one
  assign rd_addr = in_accept ? res_d.addr : stg_q.addr;

  always_ff @(posedge clk_i) begin
    rd_data_q <= key_mem[rd_addr];
    if (adv_store && stg_q.byte_wr) begin
      key_mem[stg_q.addr] <= new_byte;
    end
  end

  // Capture the last write for a read issued at the same edge
  always_ff @(posedge clk_i) begin
    fwd_addr_q <= stg_q.addr;
    fwd_data_q <= new_byte;
  end

  // Merge the nibble into the stored byte
  assign old_byte = (fwd_valid_q && fwd_addr_q == stg_q.addr) ? fwd_data_q : rd_data_q;
  assign new_byte = stg_q.high_nib ? {stg_q.nibble, 4'b0000}
                                   : old_byte + {4'b0000, stg_q.nibble};

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv_store) begin
      out_q      <= stg_q;
      out_byte_q <= stg_q.byte_wr ? new_byte : '0;
    end
  end

  // Drive the result ports
  assign out_valid_o    = out_valid_q;
  assign reply_o        = out_q.reply;
  assign target_o       = out_q.target;
  assign byte_written_o = out_q.byte_wr;
  assign byte_index_o   = out_q.byte_idx;
  assign byte_value_o   = out_byte_q;
  assign zone_code_o    = out_q.zone;
  assign done_mask_o    = out_q.mask;
  assign all_done_o     = out_q.all_done;
  assign hide_key_o     = out_q.hide_key;

endmodule
